// ===== src/mccm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mccm_pkg
// Shared types, key tables and fixed-point widths for the monotone cubic
// colour map.
// ----------------------------------------------------------------------------
package mccm_pkg;

  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned KEY_COUNT     = 5;
  localparam int unsigned SEG_W         = $clog2(KEY_COUNT - 1);
  localparam int unsigned CH_COUNT      = 3;
  localparam int unsigned COLOR_W       = 8;
  localparam int unsigned LATENCY       = 11;

  // position scaled to 1/10000 units
  localparam int unsigned POS_UNITS = 10000;
  localparam int unsigned UNITS_W   = 14;
  localparam int unsigned XS_W      = POSITION_BITS + UNITS_W;
  localparam int unsigned DX_W      = 28;

  // t = (dx * recip) >> 32, recip split into two halves
  localparam int unsigned RECIP_W    = 22;
  localparam int unsigned RECIP_LO_W = 11;
  localparam int unsigned RECIP_HI_W = RECIP_W - RECIP_LO_W;
  localparam int unsigned PP_W       = DX_W + RECIP_LO_W;
  localparam int unsigned TF_W       = DX_W + RECIP_W;
  localparam int unsigned T_SHIFT    = POSITION_BITS + 16;
  localparam int unsigned TR_W       = TF_W - T_SHIFT;

  localparam int unsigned T_W   = 16;
  localparam int unsigned U_W   = T_W + 1;
  localparam int unsigned T2_W  = 2 * T_W;
  localparam int unsigned U2_W  = 2 * U_W;
  localparam int unsigned A_W   = T_W + 2;
  localparam int unsigned PB_W  = U2_W + A_W;
  localparam int unsigned B_W   = 33;
  localparam int unsigned B_SHIFT = 16;

  localparam logic [T_W-1:0] T_MAX = '1;
  localparam logic [U_W-1:0] T_ONE = U_W'(1) << T_W;
  localparam logic [A_W-1:0] T_THREE = A_W'(3) << T_W;

  // channel sum at scale COLOR_SCALE * 2^32
  localparam int          COLOR_SCALE = 640000;
  localparam int unsigned TAN_W   = 17;
  localparam int unsigned P_W     = 28;
  localparam int unsigned M_W     = 29;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned QF_W    = ACC_W - 32;
  localparam int unsigned Q_W     = 28;
  localparam int unsigned DIV_SHIFT = 48;
  localparam int unsigned DR_W    = 29;
  localparam int unsigned DP_W    = Q_W + DR_W;
  localparam int unsigned EST_W   = DP_W - DIV_SHIFT;
  localparam int unsigned REM_W   = Q_W + 1;

  localparam logic [DR_W-1:0] DIV_RECIP =
    DR_W'(64'd281474976710656 / 64'd640000);
  localparam logic [QF_W-1:0] SAT_Q = QF_W'(256 * COLOR_SCALE);
  localparam logic [COLOR_W-1:0] COLOR_MAX = '1;

  localparam logic [UNITS_W-1:0] KEY_POS [KEY_COUNT] =
    '{14'd0, 14'd1600, 14'd4200, 14'd6425, 14'd10100};

  // floor(2^32 / segment width)
  localparam logic [RECIP_W-1:0] SEG_RECIP [KEY_COUNT-1] = '{
    22'(64'd4294967296 / 64'd1600),
    22'(64'd4294967296 / 64'd2600),
    22'(64'd4294967296 / 64'd2225),
    22'(64'd4294967296 / 64'd3675)
  };

  localparam logic [COLOR_W-1:0] KEY_RGB [KEY_COUNT][CH_COUNT] = '{
    '{8'd0,   8'd7,   8'd100},
    '{8'd32,  8'd107, 8'd203},
    '{8'd237, 8'd255, 8'd255},
    '{8'd255, 8'd170, 8'd0},
    '{8'd255, 8'd255, 8'd255}
  };

  // signed Q10.6 tangents
  localparam logic signed [TAN_W-1:0] KEY_TAN [KEY_COUNT][CH_COUNT] = '{
    '{17'sd12800, 17'sd40000, 17'sd41200},
    '{17'sd31631, 17'sd38215, 17'sd27000},
    '{17'sd15466, 17'sd0,     17'sd0},
    '{17'sd0,     17'sd0,     17'sd0},
    '{17'sd0,     17'sd14803, 17'sd44408}
  };

  typedef logic [SEG_W-1:0] seg_t;

  typedef struct packed {
    logic [B_W-1:0] b00;
    logic [B_W-1:0] b01;
    logic [B_W-1:0] b10;
    logic [B_W-1:0] b11;
  } basis_t;

  typedef struct packed {
    logic [P_W-1:0]        p0;
    logic [P_W-1:0]        p1;
    logic signed [M_W-1:0] m0;
    logic signed [M_W-1:0] m1;
  } coef_t;

  // per-segment weights of one channel; ch is a constant at every call
  function automatic coef_t seg_coef(input seg_t seg, input int ch);
    coef_t c;
    c = '0;
    for (int s = 0; s < KEY_COUNT - 1; s++) begin
      if (seg == SEG_W'(s)) begin
        c.p0 = P_W'(int'(KEY_RGB[s][ch]) * COLOR_SCALE);
        c.p1 = P_W'(int'(KEY_RGB[s+1][ch]) * COLOR_SCALE);
        c.m0 = M_W'(int'(KEY_TAN[s][ch]) * (int'(KEY_POS[s+1]) - int'(KEY_POS[s])));
        c.m1 = M_W'(int'(KEY_TAN[s+1][ch]) * (int'(KEY_POS[s+1]) - int'(KEY_POS[s])));
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/mccm_channel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mccm_channel
// One colour channel: weighted Hermite sum, truncation toward zero and
// saturation to 0..255. Five register stages, the last is the output register.
// ----------------------------------------------------------------------------
module mccm_channel (
  input  logic                           clk,
  input  logic                           en,
  input  mccm_pkg::basis_t               basis,
  input  mccm_pkg::coef_t                coef,
  output logic [mccm_pkg::COLOR_W-1:0]   value
);
  import mccm_pkg::*;

  logic signed [ACC_W-1:0] p0_x, p1_x, m0_x, m1_x;
  logic signed [ACC_W-1:0] b00_x, b01_x, b10_x, b11_x;
  logic signed [ACC_W-1:0] pp0_nxt, pp1_nxt, pp2_nxt, pp3_nxt;
  logic signed [ACC_W-1:0] pp0_r, pp1_r, pp2_r, pp3_r;
  logic signed [ACC_W-1:0] s01_nxt, s23_nxt, s01_r, s23_r;
  logic signed [ACC_W-1:0] acc_nxt, acc_r;

  logic [QF_W-1:0]    q_full;
  logic [DP_W-1:0]    est_prod;
  logic               pos_nxt, pos_r, sat_nxt, sat_r;
  logic [Q_W-1:0]     qn_nxt, qn_r;
  logic [EST_W-1:0]   est_nxt, est_r;
  logic [REM_W-1:0]   rem;
  logic [EST_W-1:0]   quo;
  logic [COLOR_W-1:0] value_nxt, value_r;

  // products
  always_comb begin
    p0_x    = ACC_W'($signed({1'b0, coef.p0}));
    p1_x    = ACC_W'($signed({1'b0, coef.p1}));
    m0_x    = ACC_W'($signed(coef.m0));
    m1_x    = ACC_W'($signed(coef.m1));
    b00_x   = ACC_W'($signed({1'b0, basis.b00}));
    b01_x   = ACC_W'($signed({1'b0, basis.b01}));
    b10_x   = ACC_W'($signed({1'b0, basis.b10}));
    b11_x   = ACC_W'($signed({1'b0, basis.b11}));
    pp0_nxt = p0_x * b00_x;
    pp1_nxt = p1_x * b01_x;
    pp2_nxt = m0_x * b10_x;
    pp3_nxt = m1_x * b11_x;
  end

  assign s01_nxt = pp0_r + pp1_r;
  assign s23_nxt = pp2_r - pp3_r;
  assign acc_nxt = s01_r + s23_r;

  // quotient estimate by reciprocal, at most one short
  always_comb begin
    q_full   = acc_r[ACC_W-1:ACC_W-QF_W];
    pos_nxt  = ~acc_r[ACC_W-1] & (|acc_r);
    sat_nxt  = q_full >= SAT_Q;
    qn_nxt   = q_full[Q_W-1:0];
    est_prod = DP_W'(qn_nxt) * DP_W'(DIV_RECIP);
    est_nxt  = est_prod[DIV_SHIFT +: EST_W];
  end

  always_comb begin
    rem = REM_W'(qn_r) - REM_W'(est_r) * REM_W'(COLOR_SCALE);
    quo = est_r + EST_W'(rem >= REM_W'(COLOR_SCALE));
    if (!pos_r) begin
      value_nxt = '0;
    end else if (sat_r) begin
      value_nxt = COLOR_MAX;
    end else begin
      value_nxt = quo[COLOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp0_r   <= pp0_nxt;
      pp1_r   <= pp1_nxt;
      pp2_r   <= pp2_nxt;
      pp3_r   <= pp3_nxt;
      s01_r   <= s01_nxt;
      s23_r   <= s23_nxt;
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      sat_r   <= sat_nxt;
      qn_r    <= qn_nxt;
      est_r   <= est_nxt;
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule
`default_nettype wire

// ===== src/monotone_cubic_color_map.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// monotone_cubic_color_map
// Maps a Q0.16 palette position to RGB by monotone cubic Hermite
// interpolation over five fixed key colours.
// ----------------------------------------------------------------------------
// Takes one position per clock, unless stalled, and returns its colour through
// the eleven register stages of the multiplier pipeline (scale, segment
// select, reciprocal product, t, squares, basis, channel products, two adds,
// divide estimate, correction). The pipeline advances as one: while a
// result waits at the output under out_stall the whole pipeline holds and
// in_stall is raised; otherwise a request is taken every cycle.
module monotone_cubic_color_map (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mccm_pkg::POSITION_BITS-1:0]  in_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mccm_pkg::COLOR_W-1:0]        out_red,
  output logic [mccm_pkg::COLOR_W-1:0]        out_green,
  output logic [mccm_pkg::COLOR_W-1:0]        out_blue
);
  import mccm_pkg::*;

  logic               en;
  logic [LATENCY-1:0] vld_r;

  logic [XS_W-1:0]       xs1_nxt, xs1_r;
  seg_t                  seg2_nxt, seg2_r, seg3_r, seg4_r, seg5_r;
  logic [XS_W-1:0]       base;
  logic [DX_W-1:0]       dx2_nxt, dx2_r;
  logic [RECIP_W-1:0]    recip;
  logic [PP_W-1:0]       ph3_nxt, pl3_nxt, ph3_r, pl3_r;
  logic [TF_W-1:0]       tfull;
  logic [TR_W-1:0]       traw;
  logic [T_W-1:0]        t4_nxt, t4_r, t5_r;
  logic [U_W-1:0]        u4_nxt, u4_r, u5_r;
  logic [T2_W-1:0]       tsq5_nxt, tsq5_r;
  logic [U2_W-1:0]       usq5_nxt, usq5_r;
  logic [A_W-1:0]        a_w, c_w;
  logic [PB_W-1:0]       prod00, prod01, prod10, prod11;
  basis_t                basis6_nxt, basis6_r;
  logic [COLOR_W-1:0]    chan_value [CH_COUNT];

  assign en        = ~(vld_r[LATENCY-1] & out_stall);
  assign in_stall  = ~en;
  assign out_valid = vld_r[LATENCY-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LATENCY-2:0], in_valid};
    end
  end

  assign xs1_nxt = XS_W'(in_position) * XS_W'(POS_UNITS);

  // first key above the position
  always_comb begin
    seg2_nxt = SEG_W'(KEY_COUNT - 2);
    base     = XS_W'(KEY_POS[KEY_COUNT-2]) << POSITION_BITS;
    for (int i = KEY_COUNT - 2; i >= 0; i--) begin
      if (xs1_r < (XS_W'(KEY_POS[i+1]) << POSITION_BITS)) begin
        seg2_nxt = SEG_W'(i);
        base     = XS_W'(KEY_POS[i]) << POSITION_BITS;
      end
    end
    dx2_nxt = DX_W'(xs1_r - base);
  end

  always_comb begin
    recip   = SEG_RECIP[seg2_r];
    ph3_nxt = PP_W'(dx2_r) * PP_W'(recip[RECIP_W-1:RECIP_LO_W]);
    pl3_nxt = PP_W'(dx2_r) * PP_W'(recip[RECIP_LO_W-1:0]);
  end

  always_comb begin
    tfull  = (TF_W'(ph3_r) << RECIP_LO_W) + TF_W'(pl3_r);
    traw   = tfull[TF_W-1:T_SHIFT];
    t4_nxt = (traw > TR_W'(T_MAX)) ? T_MAX : traw[T_W-1:0];
    u4_nxt = T_ONE - U_W'(t4_nxt);
  end

  assign tsq5_nxt = T2_W'(t4_r) * T2_W'(t4_r);
  assign usq5_nxt = U2_W'(u4_r) * U2_W'(u4_r);

  always_comb begin
    a_w    = A_W'(T_ONE) + (A_W'(t5_r) << 1);
    c_w    = T_THREE - (A_W'(t5_r) << 1);
    prod00 = PB_W'(a_w) * PB_W'(usq5_r);
    prod10 = PB_W'(t5_r) * PB_W'(usq5_r);
    prod01 = PB_W'(tsq5_r) * PB_W'(c_w);
    prod11 = PB_W'(tsq5_r) * PB_W'(u5_r);
    basis6_nxt.b00 = prod00[B_SHIFT +: B_W];
    basis6_nxt.b01 = prod01[B_SHIFT +: B_W];
    basis6_nxt.b10 = prod10[B_SHIFT +: B_W];
    basis6_nxt.b11 = prod11[B_SHIFT +: B_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs1_r    <= xs1_nxt;
      seg2_r   <= seg2_nxt;
      dx2_r    <= dx2_nxt;
      seg3_r   <= seg2_r;
      ph3_r    <= ph3_nxt;
      pl3_r    <= pl3_nxt;
      seg4_r   <= seg3_r;
      t4_r     <= t4_nxt;
      u4_r     <= u4_nxt;
      seg5_r   <= seg4_r;
      t5_r     <= t4_r;
      u5_r     <= u4_r;
      tsq5_r   <= tsq5_nxt;
      usq5_r   <= usq5_nxt;
      basis6_r <= basis6_nxt;
    end
  end

  for (genvar ch = 0; ch < CH_COUNT; ch++) begin : g_ch
    coef_t coef6_nxt, coef6_r;

    assign coef6_nxt = seg_coef(seg5_r, ch);

    always_ff @(posedge clk) begin
      if (en) begin
        coef6_r <= coef6_nxt;
      end
    end

    mccm_channel u_channel (
      .clk   (clk),
      .en    (en),
      .basis (basis6_r),
      .coef  (coef6_r),
      .value (chan_value[ch])
    );
  end

  assign out_red   = chan_value[0];
  assign out_green = chan_value[1];
  assign out_blue  = chan_value[2];

endmodule
`default_nettype wire

// ===== src/mccm_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mccm_checker
// Port-level checks for the colour map, bound to the top level.
// ----------------------------------------------------------------------------
module mccm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [mccm_pkg::POSITION_BITS-1:0]  in_position,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [mccm_pkg::COLOR_W-1:0]        out_red,
  input logic [mccm_pkg::COLOR_W-1:0]        out_green,
  input logic [mccm_pkg::COLOR_W-1:0]        out_blue
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented straight after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_position))
    else $error("stalled request changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while pipeline held");

  a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind monotone_cubic_color_map mccm_checker u_mccm_checker (.*);
`default_nettype wire
